// ----- sv/pevq_pkg.sv -----
// Shared types and constants for the pointer event report queue.
// Used by the divider and the top-level sequencer; depends on nothing.

package pevq_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int LIMIT_W = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam int COORD_W = 16;
  localparam int ABS_SHIFT = 15;
  localparam int DIVIDEND_W = 32;
  localparam int DIV_STEPS = DIVIDEND_W / 2;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam int BUTTON_W = 3;
  localparam int SRC_BUTTON_W = 4;
  localparam int WHEEL_W = 8;
  localparam int ENTRY_W = BUTTON_W + 2 * COORD_W + WHEEL_W;

  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 48;
  localparam int STATUS_W = 2;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_POLL = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REPORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NAK = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [COORD_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- sv/pevq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the queued events; depends on nothing.

module pevq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/pevq_div.sv -----
// Iterative restoring divider, two quotient bits per cycle, low 16 quotient bits kept.
// Shared by the x and y scaling; depends on pevq_pkg.

module pevq_div
  import pevq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic                  done;
  logic [STEP_W-1:0]     cnt;
  logic [COORD_W-1:0]    divisor;
  logic [COORD_W-1:0]    rem;
  logic [DIVIDEND_W-1:0] dvd;
  logic [COORD_W-1:0]    quo;

  logic [COORD_W:0]   t1;
  logic [COORD_W:0]   t2;
  logic               ge1;
  logic               ge2;
  logic [COORD_W-1:0] r1;
  logic [COORD_W-1:0] r2;

  always_comb begin
    t1  = {rem, dvd[DIVIDEND_W-1]};
    ge1 = t1 >= {1'b0, divisor};
    r1  = ge1 ? COORD_W'(t1 - {1'b0, divisor}) : t1[COORD_W-1:0];
    t2  = {r1, dvd[DIVIDEND_W-2]};
    ge2 = t2 >= {1'b0, divisor};
    r2  = ge2 ? COORD_W'(t2 - {1'b0, divisor}) : t2[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      dvd     <= req.dividend;
      rem     <= '0;
      quo     <= '0;
    end else if (busy) begin
      rem <= r2;
      dvd <= {dvd[DIVIDEND_W-3:0], 2'b00};
      quo <= {quo[COORD_W-3:0], ge1, ge2};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- sv/pointer_event_report_queue_core.sv -----
// Between the edge that takes a request and the first edge that can take its result, an event
// makes two passes through the shared divider (x, then y), each of 16 two-bit steps, and is
// then queued; a report reads the RAM, then registers the entry; a NAK goes straight out.
// One request is handled at a time: the next is taken the cycle after the result is taken.
// Reset (rst, synchronous) empties the queue and sets the queue limit to 16; the event RAM
// is not cleared. Depends on pevq_pkg, pevq_div and pevq_ram.

module pointer_event_report_queue_core
  import pevq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [LIMIT_W-1:0]    cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // source_buttons[3:0], pixel_x[19:4], pixel_y[35:20], wheel_delta[43:36],
  // width[59:44], height[75:60], zero[79:76]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation[0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // dropped_oldest[0], report_buttons[3:1], report_x[19:4], report_y[35:20],
  // report_wheel[43:36], zero[47:44]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [STATUS_W-1:0]   m_axis_tuser
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIVX = 5'b00010,
    S_DIVY = 5'b00100,
    S_READ = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  logic [LIMIT_W-1:0] lim;
  logic [IDX_W-1:0]   oldest;
  logic [CNT_W-1:0]   held;

  logic [BUTTON_W-1:0]      ev_buttons;
  logic signed [WHEEL_W-1:0] ev_wheel;
  logic [COORD_W-1:0]       ev_y;
  logic [COORD_W-1:0]       ev_height;
  logic [COORD_W-1:0]       qx;

  logic [STATUS_W-1:0]       out_status;
  logic                      out_dropped;
  logic [BUTTON_W-1:0]       out_buttons;
  logic [COORD_W-1:0]        out_x;
  logic [COORD_W-1:0]        out_y;
  logic signed [WHEEL_W-1:0] out_wheel;

  logic [SRC_BUTTON_W-1:0] in_src;
  logic [COORD_W-1:0]      in_x;
  logic [COORD_W-1:0]      in_y;
  logic [WHEEL_W-1:0]      in_wheel;
  logic [COORD_W-1:0]      in_width;
  logic [COORD_W-1:0]      in_height;
  logic                    in_take;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CMP_W-1:0]   lim_cmp;
  logic [CNT_W-1:0]   lim_eff;
  logic               drop;
  logic [CNT_W-1:0]   evict_n;
  logic [SUM_W-1:0]   adv_sum;
  logic [IDX_W-1:0]   oldest_adv;
  logic [CNT_W-1:0]   held_base;
  logic [SUM_W-1:0]   slot_sum;
  logic [IDX_W-1:0]   slot;
  logic [SUM_W-1:0]   inc_sum;
  logic [IDX_W-1:0]   oldest_inc;

  logic               ram_we;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  assign in_src    = s_axis_tdata[3:0];
  assign in_x      = s_axis_tdata[19:4];
  assign in_y      = s_axis_tdata[35:20];
  assign in_wheel  = s_axis_tdata[43:36];
  assign in_width  = s_axis_tdata[59:44];
  assign in_height = s_axis_tdata[75:60];

  assign s_axis_tready = (state == S_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, in_x, ABS_SHIFT'(0)};
    div_req.divisor  = in_width;
    if (state == S_DIVX) begin
      div_req.start    = div_rsp.done;
      div_req.dividend = {1'b0, ev_y, ABS_SHIFT'(0)};
      div_req.divisor  = ev_height;
    end else if (in_take && s_axis_tuser == OP_EVENT) begin
      div_req.start = 1'b1;
    end
  end

  pevq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    if (lim == '0) begin
      lim_cmp = CMP_W'(1);
    end else if (CMP_W'(lim) > CMP_W'(QUEUE_DEPTH)) begin
      lim_cmp = CMP_W'(QUEUE_DEPTH);
    end else begin
      lim_cmp = CMP_W'(lim);
    end
    lim_eff = lim_cmp[CNT_W-1:0];
    drop    = held >= lim_eff;
    evict_n = held - lim_eff + 1'b1;
    adv_sum = SUM_W'(oldest) + SUM_W'(evict_n);
    if (!drop) begin
      oldest_adv = oldest;
    end else if (adv_sum >= SUM_W'(QUEUE_DEPTH)) begin
      oldest_adv = IDX_W'(adv_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      oldest_adv = adv_sum[IDX_W-1:0];
    end
    held_base = drop ? lim_eff - 1'b1 : held;
    slot_sum  = SUM_W'(oldest_adv) + SUM_W'(held_base);
    if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
      slot = IDX_W'(slot_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      slot = slot_sum[IDX_W-1:0];
    end
    inc_sum = SUM_W'(oldest) + 1'b1;
    if (inc_sum == SUM_W'(QUEUE_DEPTH)) begin
      oldest_inc = '0;
    end else begin
      oldest_inc = inc_sum[IDX_W-1:0];
    end
  end

  assign ram_we    = (state == S_DIVY) && div_rsp.done;
  assign ram_wdata = {ev_buttons, qx, div_rsp.quotient, ev_wheel};
  assign ram_re    = in_take && s_axis_tuser == OP_POLL && held != '0;

  pevq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (oldest),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= LIMIT_RESET;
    end else if (cfg_we) begin
      lim <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      oldest <= '0;
      held   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (s_axis_tuser == OP_EVENT) begin
              state <= S_DIVX;
            end else if (held == '0) begin
              state <= S_OUT;
            end else begin
              oldest <= oldest_inc;
              held   <= held - 1'b1;
              state  <= S_READ;
            end
          end
        end
        S_DIVX: begin
          if (div_rsp.done) begin
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_rsp.done) begin
            oldest <= oldest_adv;
            held   <= held_base + 1'b1;
            state  <= S_OUT;
          end
        end
        S_READ: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ev_buttons <= {in_src[2], in_src[3], in_src[1]};
      ev_wheel   <= in_wheel;
      ev_y       <= in_y;
      ev_height  <= in_height;
      out_status  <= ST_NAK;
      out_dropped <= 1'b0;
      out_buttons <= '0;
      out_x       <= '0;
      out_y       <= '0;
      out_wheel   <= '0;
    end
    if (state == S_DIVX && div_rsp.done) begin
      qx <= div_rsp.quotient;
    end
    if (state == S_DIVY && div_rsp.done) begin
      out_status  <= ST_ACCEPTED;
      out_dropped <= drop;
    end
    if (state == S_READ) begin
      out_status  <= ST_REPORT;
      out_dropped <= 1'b0;
      {out_buttons, out_x, out_y, out_wheel} <= ram_rdata;
    end
  end

  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {4'b0000, out_wheel, out_y, out_x, out_buttons, out_dropped};

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(QUEUE_DEPTH))
    else $error("held count exceeds queue depth");

  a_oldest_bound: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(oldest) < SUM_W'(QUEUE_DEPTH))
    else $error("oldest index out of range");

  a_nak_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_NAK |-> m_axis_tdata == '0)
    else $error("NAK result carries a payload");

  a_event_queued: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVY && div_rsp.done |=> held != '0 && m_axis_tuser == ST_ACCEPTED)
    else $error("queued event left the queue empty");
`endif

endmodule

// ----- tb/sv/pointer_event_report_queue_core_tb.sv -----
// Self-checking testbench for pointer_event_report_queue_core: a directed table, then random
// phases at several queue limits, results checked against the table or in-bench queue model.
// Depends on pevq_pkg and the core with its divider and RAM.

module pointer_event_report_queue_core_tb
  import pevq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = QUEUE_DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int EXP_RING = 64;

  typedef struct packed {
    logic                    op;
    logic [SRC_BUTTON_W-1:0] buttons;
    logic [COORD_W-1:0]      px;
    logic [COORD_W-1:0]      py;
    logic [WHEEL_W-1:0]      wheel;
    logic [COORD_W-1:0]      sw;
    logic [COORD_W-1:0]      sh;
  } pointer_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                dropped;
    logic [BUTTON_W-1:0] buttons;
    logic [COORD_W-1:0]  rx;
    logic [COORD_W-1:0]  ry;
    logic [WHEEL_W-1:0]  wheel;
  } report_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    pointer_req_t       req;
    logic               typed;
    report_t            exp;
  } vector_t;

  localparam int DIRECTED_N = 25;
  localparam vector_t DIRECTED [0:DIRECTED_N-1] = '{
    '{5'd16, '{OP_POLL, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001}, 1'b1,
      '{ST_NAK, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h00}},
    '{5'd16, '{OP_EVENT, 4'hF, 16'hFFFF, 16'hFFFF, 8'h7F, 16'h0001, 16'h0001}, 1'b1,
      '{ST_ACCEPTED, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h00}},
    '{5'd16, '{OP_POLL, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001}, 1'b1,
      '{ST_REPORT, 1'b0, 3'd7, 16'h8000, 16'h8000, 8'h7F}},
    '{5'd16, '{OP_EVENT, 4'h1, 16'h0000, 16'h0000, 8'h80, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{ST_ACCEPTED, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h00}},
    '{5'd16, '{OP_POLL, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001}, 1'b1,
      '{ST_REPORT, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h80}},
    '{5'd16, '{OP_EVENT, 4'h2, 16'hFFFF, 16'hFFFF, 8'h00, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{ST_ACCEPTED, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h00}},
    '{5'd16, '{OP_EVENT, 4'h4, 16'h0064, 16'h00C8, 8'h01, 16'h0780, 16'h0438}, 1'b0, '0},
    '{5'd16, '{OP_EVENT, 4'h8, 16'h3039, 16'hD431, 8'hFF, 16'h0003, 16'h0007}, 1'b0, '0},
    '{5'd16, '{OP_EVENT, 4'h0, 16'h0001, 16'h0001, 8'h00, 16'h0002, 16'hFFFF}, 1'b0, '0},
    '{5'd16, '{OP_POLL, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001}, 1'b1,
      '{ST_REPORT, 1'b0, 3'd1, 16'h8000, 16'h8000, 8'h00}},
    '{5'd16, '{OP_POLL, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{5'd16, '{OP_POLL, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001}, 1'b0, '0},
    '{5'd16, '{OP_POLL, 4'h5, 16'h1234, 16'h5678, 8'h9A, 16'h0100, 16'h0200}, 1'b0, '0},
    '{5'd16, '{OP_POLL, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001}, 1'b1,
      '{ST_NAK, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h00}},
    '{5'd1, '{OP_EVENT, 4'h8, 16'h1234, 16'h4321, 8'h55, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{ST_ACCEPTED, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h00}},
    '{5'd1, '{OP_EVENT, 4'h6, 16'hFFFF, 16'h0000, 8'hAA, 16'h0001, 16'h0001}, 1'b1,
      '{ST_ACCEPTED, 1'b1, 3'd0, 16'h0000, 16'h0000, 8'h00}},
    '{5'd1, '{OP_POLL, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001}, 1'b1,
      '{ST_REPORT, 1'b0, 3'd5, 16'h8000, 16'h0000, 8'hAA}},
    '{5'd1, '{OP_POLL, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001}, 1'b1,
      '{ST_NAK, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h00}},
    '{5'd16, '{OP_EVENT, 4'hA, 16'h0100, 16'h0200, 8'h10, 16'h0400, 16'h0400}, 1'b1,
      '{ST_ACCEPTED, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h00}},
    '{5'd16, '{OP_EVENT, 4'h5, 16'h7FFF, 16'h8000, 8'hF0, 16'h8000, 16'h7FFF}, 1'b1,
      '{ST_ACCEPTED, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h00}},
    '{5'd16, '{OP_EVENT, 4'hE, 16'hABCD, 16'h0F0F, 8'h7F, 16'h00FF, 16'h1000}, 1'b1,
      '{ST_ACCEPTED, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h00}},
    '{5'd2, '{OP_EVENT, 4'h3, 16'h0010, 16'h0020, 8'h81, 16'h0040, 16'h0040}, 1'b1,
      '{ST_ACCEPTED, 1'b1, 3'd0, 16'h0000, 16'h0000, 8'h00}},
    '{5'd2, '{OP_POLL, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001}, 1'b0, '0},
    '{5'd2, '{OP_POLL, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001}, 1'b0, '0},
    '{5'd2, '{OP_POLL, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001}, 1'b1,
      '{ST_NAK, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h00}}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = OP_EVENT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  report_t expected_ring [EXP_RING];
  int      exp_head = 0;
  int      exp_tail = 0;
  report_t stored_events [DEPTH];
  int      oldest_slot = 0;
  int      stored_count = 0;
  int      queue_limit_shadow = int'(LIMIT_RESET);
  int      mismatch_count = 0;
  int      cycle_count = 0;
  bit      quiet = 1'b0;
  bit      hold_off_req = 1'b0;

  pointer_event_report_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [COORD_W-1:0] scale_to_abs(input logic [COORD_W-1:0] pos,
                                                      input logic [COORD_W-1:0] size);
    logic [DIVIDEND_W-1:0] quot;
    if (size == '0) begin
      return '1;
    end
    quot = ({16'd0, pos} << ABS_SHIFT) / {16'd0, size};
    return quot[COORD_W-1:0];
  endfunction

  function automatic report_t predict_report(input pointer_req_t r);
    report_t res;
    report_t ent;
    int lim;
    res = '0;
    if (r.op == OP_EVENT) begin
      lim = queue_limit_shadow;
      if (lim < 1) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      ent = '0;
      ent.buttons = {r.buttons[2], r.buttons[3], r.buttons[1]};
      ent.rx = scale_to_abs(r.px, r.sw);
      ent.ry = scale_to_abs(r.py, r.sh);
      ent.wheel = r.wheel;
      while (stored_count >= lim) begin
        oldest_slot = (oldest_slot + 1) % DEPTH;
        stored_count--;
        res.dropped = 1'b1;
      end
      stored_events[(oldest_slot + stored_count) % DEPTH] = ent;
      stored_count++;
      res.status = ST_ACCEPTED;
    end else if (stored_count == 0) begin
      res.status = ST_NAK;
    end else begin
      res = stored_events[oldest_slot];
      res.status = ST_REPORT;
      res.dropped = 1'b0;
      oldest_slot = (oldest_slot + 1) % DEPTH;
      stored_count--;
    end
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] random_pixel();
    logic [31:0] rnd;
    rnd = $urandom;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return COORD_W'(rnd[3:0]);
      default: return rnd[COORD_W-1:0];
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] random_size();
    case ($urandom_range(0, 7))
      0: return 16'd1;
      1: return '1;
      2: return COORD_W'($urandom_range(1, 16));
      default: return COORD_W'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic pointer_req_t random_request(input int poll_pct);
    pointer_req_t r;
    logic [31:0] rnd;
    rnd = $urandom;
    r.op = ($urandom_range(0, 99) < poll_pct) ? OP_POLL : OP_EVENT;
    r.buttons = rnd[3:0];
    r.wheel = rnd[15:8];
    r.px = random_pixel();
    r.py = random_pixel();
    r.sw = random_size();
    r.sh = random_size();
    if ($urandom_range(0, 9) == 0) r.px = r.sw;
    return r;
  endfunction

  task automatic send_request(input pointer_req_t r, input logic typed, input report_t exp);
    report_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.op;
    s_axis_tdata <= {4'd0, r.sh, r.sw, r.wheel, r.py, r.px, r.buttons};
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_report(r);
    expected_ring[exp_tail % EXP_RING] = typed ? exp : predicted;
    exp_tail++;
  endtask

  task automatic maybe_pause();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_for_reports();
    s_axis_tvalid <= 1'b0;
    while (exp_tail != exp_head) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_limit(input int value);
    wait_for_reports();
    cfg_we <= 1'b1;
    cfg_wdata <= value[LIMIT_W-1:0];
    @(posedge clk);
    queue_limit_shadow = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : receiver
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : monitor
    report_t exp;
    report_t got;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.dropped = m_axis_tdata[0];
        got.buttons = m_axis_tdata[3:1];
        got.rx = m_axis_tdata[19:4];
        got.ry = m_axis_tdata[35:20];
        got.wheel = m_axis_tdata[43:36];
        if (exp_tail == exp_head) begin
          $error("result with no request outstanding: status %0d", got.status);
          mismatch_count++;
        end else begin
          exp = expected_ring[exp_head % EXP_RING];
          exp_head++;
          if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            mismatch_count++;
          end
          if (got.dropped !== exp.dropped) begin
            $error("dropped_oldest: expected %0d, got %0d", exp.dropped, got.dropped);
            mismatch_count++;
          end
          if (got.buttons !== exp.buttons) begin
            $error("report_buttons: expected %0d, got %0d", exp.buttons, got.buttons);
            mismatch_count++;
          end
          if (got.rx !== exp.rx) begin
            $error("report_x: expected %h, got %h", exp.rx, got.rx);
            mismatch_count++;
          end
          if (got.ry !== exp.ry) begin
            $error("report_y: expected %h, got %h", exp.ry, got.ry);
            mismatch_count++;
          end
          if (got.wheel !== exp.wheel) begin
            $error("report_wheel: expected %h, got %h", exp.wheel, got.wheel);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    vector_t v;
    int new_limit;
    int poll_pct;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DIRECTED_N; i++) begin
      v = DIRECTED[i];
      if (int'(v.limit) != queue_limit_shadow) set_limit(int'(v.limit));
      maybe_pause();
      send_request(v.req, v.typed, v.exp);
    end
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0, 3, 8: new_limit = 16;
        1:       new_limit = 1;
        4:       new_limit = 2;
        6:       new_limit = 15;
        default: new_limit = $urandom_range(1, 16);
      endcase
      set_limit(new_limit);
      quiet = (phase == PHASES - 1);
      poll_pct = (phase == 0) ? 5 : $urandom_range(20, 70);
      if (phase == 2) hold_off_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 4 && n == ITEMS_PER_PHASE / 2) wait_for_reports();
        maybe_pause();
        send_request(random_request(poll_pct), 1'b0, '0);
      end
    end
    wait_for_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && exp_tail == exp_head) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
